// ===== src/button_debounce_press_classifier_core_macros.svh =====
// Assertion macros for the button debounce and press classifier.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication checked at every rising clock edge outside reset.
`define BDPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked at every rising clock edge outside reset.
`define BDPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BDPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define BDPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/bdpc_pkg.sv =====
// Shared types and constants for the button debounce and press classifier.
// No dependencies; used by the configuration channel interface and the core.
package bdpc_pkg;

  // Register field widths.
  localparam int RUN_W    = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Default module parameters.
  localparam int TICK_COUNT_WIDTH_DEFAULT = 16;
  localparam int RUN_LIMIT_DEFAULT        = 255;

  // Register reset values.
  localparam logic [RUN_W-1:0] DEBOUNCE_REPEAT_RESET  = 8'd2;
  localparam logic [CFG_W-1:0] LONG_HOLD_TICKS_RESET  = 16'd30;
  localparam logic [CFG_W-1:0] BOOT_GRACE_TICKS_RESET = 16'd40;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_REPEAT  = 2'd0,
    CFG_LONG_HOLD_TICKS  = 2'd1,
    CFG_BOOT_GRACE_TICKS = 2'd2
  } cfg_index_t;

  // Bit positions in the sticky event flags.
  localparam int FLAG_SHORT   = 0;
  localparam int FLAG_LONG    = 1;
  localparam int FLAG_RELEASE = 2;
  localparam int FLAG_W       = 3;

endpackage

// ===== src/bdpc_channels.sv =====
// Valid/ready channel interfaces for ticks, results and configuration writes.
// Depends on bdpc_pkg for the configuration field widths.

// One poll tick: raw level and acknowledge bits.
interface bdpc_tick_if;
  logic valid;
  logic ready;
  logic raw_level;
  logic ack_short;
  logic ack_long;
  logic ack_release;
  modport source (output valid, raw_level, ack_short, ack_long, ack_release, input ready);
  modport sink (input valid, raw_level, ack_short, ack_long, ack_release, output ready);
endinterface

// One result: debounced level and sticky flags.
interface bdpc_result_if;
  logic valid;
  logic ready;
  logic steady_level;
  logic short_pending;
  logic long_pending;
  logic release_pending;
  modport source (output valid, steady_level, short_pending, long_pending, release_pending,
                  input ready);
  modport sink (input valid, steady_level, short_pending, long_pending, release_pending,
                output ready);
endinterface

// Configuration register write.
interface bdpc_cfg_if import bdpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/button_debounce_press_classifier_core.sv =====
// Button debounce and short/long press classifier, top level.
// Depends on bdpc_pkg, the bdpc channel interfaces and the assertion macro header.
//
//   channel  direction  carries                                        width
//   tick     in         raw_level, ack_short, ack_long, ack_release    4
//   result   out        steady_level, short/long/release_pending       4
//   cfg      in         index, data (write only, always ready)         2 + 16
//
// One tick is taken per cycle while the result is not stalled; its result is visible in the cycle after the transfer.
// The result register is the state itself, so a tick is taken whenever the result
// register is empty or its content is being taken in the same cycle.
// A stalled result holds and blocks further ticks until it is taken.
// Reset is synchronous; it loads the register defaults and clears all state.
`include "button_debounce_press_classifier_core_macros.svh"

module button_debounce_press_classifier_core
  import bdpc_pkg::*;
#(
  parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEFAULT,
  parameter int RUN_LIMIT        = RUN_LIMIT_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  bdpc_tick_if.sink    tick,
  bdpc_result_if.source result,
  bdpc_cfg_if.sink     cfg
);

  localparam int TW    = TICK_COUNT_WIDTH;
  localparam int CMP_W = (TW > CFG_W) ? TW : CFG_W;
  localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

  // Configuration registers.
  logic [RUN_W-1:0] debounce_repeat;
  logic [CFG_W-1:0] long_hold_ticks;
  logic [CFG_W-1:0] boot_grace_ticks;

  // Classifier state.
  logic              previous_raw, previous_raw_next;
  logic [RUN_W-1:0]  equal_run, equal_run_next;
  logic              confirmed_level, confirmed_level_next;
  logic              edge_reference, edge_reference_next;
  logic              reference_seeded;
  logic [TW-1:0]     hold_ticks, hold_ticks_next;
  logic              long_done, long_done_next;
  logic [FLAG_W-1:0] event_flags, event_flags_next;
  logic [TW-1:0]     ticks_since_reset, ticks_since_reset_next;
  logic              out_valid;

  logic              accept;
  logic              in_grace;
  logic              rising;
  logic              edge_seen;
  logic [FLAG_W-1:0] flags_acked;

  assign cfg.ready   = 1'b1;
  assign tick.ready  = !out_valid || result.ready;
  assign accept      = tick.valid && tick.ready;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_repeat  <= DEBOUNCE_REPEAT_RESET;
      long_hold_ticks  <= LONG_HOLD_TICKS_RESET;
      boot_grace_ticks <= BOOT_GRACE_TICKS_RESET;
    end else if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        CFG_DEBOUNCE_REPEAT:  debounce_repeat  <= cfg.data[RUN_W-1:0];
        CFG_LONG_HOLD_TICKS:  long_hold_ticks  <= cfg.data;
        CFG_BOOT_GRACE_TICKS: boot_grace_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  // Tick update: acknowledge, debounce, then classify against the edge reference.
  always_comb begin
    flags_acked = event_flags & ~{tick.ack_release, tick.ack_long, tick.ack_short};

    previous_raw_next = tick.raw_level;
    if (tick.raw_level == previous_raw) begin
      equal_run_next = (equal_run < RUN_W'(RUN_LIMIT)) ? equal_run + 1'b1 : equal_run;
    end else begin
      equal_run_next = '0;
    end
    confirmed_level_next = (equal_run_next >= debounce_repeat) ? tick.raw_level
                                                               : confirmed_level;

    // The first tick seeds the reference from the confirmed level.
    edge_seen = reference_seeded ? edge_reference : confirmed_level_next;
    in_grace  = CMP_W'(ticks_since_reset) < CMP_W'(boot_grace_ticks);

    rising              = 1'b0;
    edge_reference_next = edge_seen;
    long_done_next      = long_done;
    event_flags_next    = flags_acked;
    if (in_grace) begin
      edge_reference_next = confirmed_level_next;
      event_flags_next    = '0;
    end else if (confirmed_level_next && !edge_seen) begin
      rising              = 1'b1;
      long_done_next      = 1'b0;
      edge_reference_next = 1'b1;
    end else if (confirmed_level_next && edge_seen) begin
      if (!long_done && (CMP_W'(hold_ticks) >= CMP_W'(long_hold_ticks))) begin
        event_flags_next[FLAG_LONG] = 1'b1;
        long_done_next              = 1'b1;
      end
    end else if (!confirmed_level_next && edge_seen) begin
      event_flags_next[FLAG_RELEASE] = 1'b1;
      if (!long_done) begin
        event_flags_next[FLAG_SHORT] = 1'b1;
      end
      edge_reference_next = 1'b0;
    end

    // Saturating tick counters.
    if (rising) begin
      hold_ticks_next = TW'(1);
    end else begin
      hold_ticks_next = (hold_ticks == TICK_MAX) ? hold_ticks : hold_ticks + 1'b1;
    end
    ticks_since_reset_next = (ticks_since_reset == TICK_MAX) ? ticks_since_reset
                                                             : ticks_since_reset + 1'b1;
  end

  // State doubles as the result register; it moves only on a tick transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw      <= 1'b0;
      equal_run         <= '0;
      confirmed_level   <= 1'b0;
      edge_reference    <= 1'b0;
      reference_seeded  <= 1'b0;
      hold_ticks        <= '0;
      long_done         <= 1'b0;
      event_flags       <= '0;
      ticks_since_reset <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (accept) begin
        previous_raw      <= previous_raw_next;
        equal_run         <= equal_run_next;
        confirmed_level   <= confirmed_level_next;
        edge_reference    <= edge_reference_next;
        reference_seeded  <= 1'b1;
        hold_ticks        <= hold_ticks_next;
        long_done         <= long_done_next;
        event_flags       <= event_flags_next;
        ticks_since_reset <= ticks_since_reset_next;
        out_valid         <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid           = out_valid;
  assign result.steady_level    = confirmed_level;
  assign result.short_pending   = event_flags[FLAG_SHORT];
  assign result.long_pending    = event_flags[FLAG_LONG];
  assign result.release_pending = event_flags[FLAG_RELEASE];

  // Grace ticks always leave every flag clear.
  `BDPC_ASSERT_NEXT(a_grace_clears, clk, rst, accept && in_grace, event_flags == '0, "flags set during grace")
  // Flags change only through a tick transfer.
  `BDPC_ASSERT_NEXT(a_flags_hold, clk, rst, !accept, $stable(event_flags), "flags moved without a tick")
  // A new long press is only reported while the button is held.
  `BDPC_ASSERT_IMPL(a_long_held, clk, rst, $rose(event_flags[FLAG_LONG]), confirmed_level, "long press while released")
  // The run counter never passes its limit.
  `BDPC_ASSERT_IMPL(a_run_limit, clk, rst, 1'b1, equal_run <= RUN_W'(RUN_LIMIT), "run counter overflow")

endmodule
